// ----- rtl/core/set_assoc_branch_target_buffer_assert.svh -----
// Assertion macros shared by the branch target buffer modules.
`ifndef SET_ASSOC_BRANCH_TARGET_BUFFER_ASSERT_SVH
`define SET_ASSOC_BRANCH_TARGET_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SABTB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SABTB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sabtb_pkg.sv -----
// Package: geometry, field types and codes of the branch target buffer.
package sabtb_pkg;

   localparam int NUM_SETS     = 16;
   localparam int NUM_WAYS     = 4;
   localparam int LINE_ENTRIES = 4;

   localparam int PC_W       = 32;
   localparam int WORD_SHIFT = 2;
   localparam int OFF_W      = $clog2(LINE_ENTRIES);
   localparam int IDX_W      = $clog2(NUM_SETS);
   localparam int WAY_W      = $clog2(NUM_WAYS);
   localparam int TAG_W      = PC_W - WORD_SHIFT - OFF_W - IDX_W;
   localparam int TGT_W      = 32;
   localparam int ADDR_W     = IDX_W + OFF_W;
   localparam int RAM_DEPTH  = NUM_SETS * LINE_ENTRIES;

   localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef logic [OFF_W-1:0]        off_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [WAY_W-1:0]        way_type;
   typedef logic [TAG_W-1:0]        tag_type;
   typedef logic [TGT_W-1:0]        tgt_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [LINE_ENTRIES-1:0] line_type;

   typedef struct packed {
      tag_type tag;
      tgt_type target;
   } entry_type;

   // One RAM row: the entry at one offset of one set, for every way.
   typedef entry_type [NUM_WAYS-1:0] row_type;
   // Valid bits of every line of a set, indexed by way.
   typedef line_type [NUM_WAYS-1:0] vrow_type;
   // Age order of a set: position 0 is the oldest way.
   typedef way_type [NUM_WAYS-1:0] age_row_type;

   typedef struct packed {
      logic    fill;
      logic    evict;
      idx_type idx;
      off_type off;
      way_type way;
   } upd_type;

   typedef struct packed {
      logic    hit;
      logic    evict;
      way_type hit_way;
      way_type victim;
   } match_type;

endpackage

// ----- rtl/core/sabtb_entry_ram.sv -----
// Tag and target storage: one row per set and offset, written one way at a time.
module sabtb_entry_ram
   import sabtb_pkg::*;
(
   input  logic      clock,
   input  logic      rd_en,
   input  addr_type  rd_addr,
   output row_type   rd_row,
   input  logic      wr_en,
   input  addr_type  wr_addr,
   input  way_type   wr_way,
   input  entry_type wr_entry
);

   entry_type entry_mem_ff [RAM_DEPTH][NUM_WAYS];
   row_type   rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr][wr_way] <= wr_entry;
      end
      if (rd_en) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            rd_row_ff[w] <= entry_mem_ff[rd_addr][w];
         end
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// ----- rtl/core/sabtb_meta.sv -----
// Valid bits and per-set FIFO age order, kept in flops.
`include "set_assoc_branch_target_buffer_assert.svh"
module sabtb_meta
   import sabtb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  idx_type     rd_idx,
   output vrow_type    valid_row,
   output age_row_type age_row,
   input  upd_type     upd
);

   vrow_type    valid_ff [NUM_SETS];
   vrow_type    valid_in [NUM_SETS];
   age_row_type age_ff   [NUM_SETS];
   age_row_type age_in   [NUM_SETS];

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      if (upd.fill) begin
         if (upd.evict) begin
            // oldest way becomes newest, its line starts over
            valid_in[upd.idx][upd.way] = line_type'(1) << upd.off;
            for (int p = 0; p < NUM_WAYS - 1; p++) begin
               age_in[upd.idx][p] = age_ff[upd.idx][p + 1];
            end
            age_in[upd.idx][NUM_WAYS - 1] = upd.way;
         end else begin
            valid_in[upd.idx][upd.way][upd.off] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
            for (int p = 0; p < NUM_WAYS; p++) begin
               age_ff[s][p] <= WAY_W'(p);
            end
         end
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
      end
   end

   assign valid_row = valid_ff[rd_idx];
   assign age_row   = age_ff[rd_idx];

   // every set must keep a permutation of the ways
   logic [NUM_WAYS-1:0] perm_seen;
   logic                perm_bad;

   always_comb begin
      perm_bad  = 1'b0;
      perm_seen = '0;
      for (int s = 0; s < NUM_SETS; s++) begin
         perm_seen = '0;
         for (int p = 0; p < NUM_WAYS; p++) begin
            perm_seen[age_ff[s][p]] = 1'b1;
         end
         if (perm_seen != '1) begin
            perm_bad = 1'b1;
         end
      end
   end

   `SABTB_ASSERT_NXT(a_fill_sets_valid, clock, reset, upd.fill,
      valid_ff[$past(upd.idx)][$past(upd.way)][$past(upd.off)], "filled entry not valid")
   `SABTB_ASSERT_NXT(a_evict_one_valid, clock, reset, upd.fill && upd.evict,
      $onehot(valid_ff[$past(upd.idx)][$past(upd.way)]), "evicted line not fresh")
   `SABTB_ASSERT_IMP(a_age_is_perm, clock, reset, 1'b1, !perm_bad,
      "age order lost a way")

endmodule

// ----- rtl/core/sabtb_match.sv -----
// Tag compare in age order, plus victim choice for a missing update.
module sabtb_match
   import sabtb_pkg::*;
(
   input  tag_type     tag,
   input  off_type     off,
   input  row_type     row,
   input  vrow_type    valid_row,
   input  age_row_type age_row,
   output match_type   res
);

   logic [NUM_WAYS-1:0] way_hit;
   logic [NUM_WAYS-1:0] way_empty;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         way_hit[w]   = valid_row[w][off] && (row[w].tag == tag);
         way_empty[w] = ~|valid_row[w];
      end
   end

   always_comb begin
      way_type wy;
      logic    have_empty;
      res        = '0;
      have_empty = 1'b0;
      // oldest first: first hit wins, last empty line is the newest one
      for (int p = 0; p < NUM_WAYS; p++) begin
         wy = age_row[p];
         if (!res.hit && way_hit[wy]) begin
            res.hit     = 1'b1;
            res.hit_way = wy;
         end
         if (way_empty[wy]) begin
            have_empty = 1'b1;
            res.victim = wy;
         end
      end
      res.evict = !have_empty;
      if (!have_empty) begin
         res.victim = age_row[0];
      end
   end

endmodule

// ----- rtl/core/set_assoc_branch_target_buffer.sv -----
// Top level: set-associative branch target buffer with FIFO way replacement.
//
// Request channel (req_*): func selects lookup or update, pc is the branch
// address, new_target the resolved target (update only). A request is taken
// on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): one response per lookup, none per update.
// predicted_target is the stored target on a hit, else pc + 4; rsp_hit flags
// the hit. A response is taken on an edge with rsp_valid high, rsp_stall low.
//
// Throughput: one request per cycle while req_stall is low. Taking a request
// loads the RAM read register with the row for {set, offset}; the compare
// stage compares the ways in age order, then either loads the response
// register (lookup) or writes the RAM and flops (update).
// An update that writes the row the next request reads is forwarded.
// When the response register is full and stalled, a lookup waiting in the
// compare stage holds and req_stall goes high until the response is taken;
// updates never wait on the response side.
// Reset: synchronous, active high. All entries become invalid at once (valid
// bits in flops) and every set gets age order way 0 oldest .. last way newest.
// No clearing pass is needed; requests are taken right after reset.
`include "set_assoc_branch_target_buffer_assert.svh"
module set_assoc_branch_target_buffer
   import sabtb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_func,
   input  logic [PC_W-1:0] req_pc,
   input  tgt_type         req_new_target,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output tgt_type         rsp_predicted_target,
   output logic            rsp_hit
);

   // compare stage
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_func_ff;
   logic [PC_W-1:0] s1_pc_ff;
   tgt_type         s1_tgt_ff;

   // forwarded write for the row now in the RAM read register
   logic            fwd_en_ff, fwd_en_in;
   way_type         fwd_way_ff;
   entry_type       fwd_entry_ff;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   tgt_type         rsp_target_ff, rsp_target_in;
   logic            rsp_hit_ff;

   logic            accept;
   logic            out_blocked;
   logic            s1_hold;
   logic            s1_write;
   logic            rsp_load;

   off_type         req_off, s1_off;
   idx_type         req_idx, s1_idx;
   tag_type         s1_tag;
   addr_type        rd_addr, wr_addr;

   row_type         ram_row;
   row_type         row;
   vrow_type        valid_row;
   age_row_type     age_row;
   match_type       mres;
   upd_type         upd;
   way_type         wr_way;
   entry_type       wr_entry;

   // address split: word offset, then set index, then tag
   assign req_off = req_pc[WORD_SHIFT +: OFF_W];
   assign req_idx = req_pc[WORD_SHIFT + OFF_W +: IDX_W];
   assign s1_off  = s1_pc_ff[WORD_SHIFT +: OFF_W];
   assign s1_idx  = s1_pc_ff[WORD_SHIFT + OFF_W +: IDX_W];
   assign s1_tag  = s1_pc_ff[PC_W-1 -: TAG_W];
   assign rd_addr = {req_idx, req_off};
   assign wr_addr = {s1_idx, s1_off};

   // handshake
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign s1_hold     = s1_valid_ff && (s1_func_ff == FUNC_LOOKUP) && out_blocked;
   assign req_stall   = s1_hold;
   assign accept      = req_valid && !req_stall;
   assign s1_write    = s1_valid_ff && (s1_func_ff == FUNC_UPDATE);
   assign rsp_load    = s1_valid_ff && (s1_func_ff == FUNC_LOOKUP) && !out_blocked;

   sabtb_entry_ram u_entry_ram (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_row   (ram_row),
      .wr_en    (s1_write),
      .wr_addr  (wr_addr),
      .wr_way   (wr_way),
      .wr_entry (wr_entry)
   );

   // patch in the write that landed after this row was read
   always_comb begin
      row = ram_row;
      if (fwd_en_ff) begin
         row[fwd_way_ff] = fwd_entry_ff;
      end
   end

   sabtb_meta u_meta (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (s1_idx),
      .valid_row (valid_row),
      .age_row   (age_row),
      .upd       (upd)
   );

   sabtb_match u_match (
      .tag       (s1_tag),
      .off       (s1_off),
      .row       (row),
      .valid_row (valid_row),
      .age_row   (age_row),
      .res       (mres)
   );

   // update: rewrite the hit entry, else fill or evict
   assign wr_way         = mres.hit ? mres.hit_way : mres.victim;
   assign wr_entry.tag    = s1_tag;
   assign wr_entry.target = s1_tgt_ff;

   assign upd.fill  = s1_write && !mres.hit;
   assign upd.evict = mres.evict;
   assign upd.idx   = s1_idx;
   assign upd.off   = s1_off;
   assign upd.way   = wr_way;

   assign fwd_en_in   = accept ? (s1_write && (wr_addr == rd_addr)) : fwd_en_ff;
   assign s1_valid_in = accept || s1_hold;

   assign rsp_target_in = mres.hit ? row[mres.hit_way].target
                                   : PC_W'(s1_pc_ff + PC_STEP);
   assign rsp_valid_in  = rsp_load || out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_en_ff    <= fwd_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff   <= req_func;
         s1_pc_ff     <= req_pc;
         s1_tgt_ff    <= req_new_target;
         fwd_way_ff   <= wr_way;
         fwd_entry_ff <= wr_entry;
      end
      if (rsp_load) begin
         rsp_target_ff <= rsp_target_in;
         rsp_hit_ff    <= mres.hit;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_hit              = rsp_hit_ff;

   `SABTB_ASSERT_NXT(a_lookup_responds, clock, reset,
      s1_valid_ff && (s1_func_ff == FUNC_LOOKUP), rsp_valid_ff, "lookup lost its response")
   `SABTB_ASSERT_NXT(a_update_silent, clock, reset,
      s1_valid_ff && (s1_func_ff == FUNC_UPDATE) && !out_blocked, !rsp_valid_ff,
      "update produced a response")
   `SABTB_ASSERT_IMP(a_hold_keeps_row, clock, reset, s1_hold,
      !accept && s1_valid_in, "held lookup lost its row")

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the set-associative branch target buffer: directed table and random traffic.
`timescale 1ns / 1ps

module tb;
   import sabtb_pkg::*;

   // Run length and pressure knobs
   localparam int CYCLE_LIMIT      = 200_000;
   localparam int RANDOM_PER_PHASE = 367;   // three phases, about 1100 requests
   localparam int LONG_HOLD        = 150;   // receiver hold-off, in cycles
   localparam int MAX_REPORTS      = 10;

   // Expected response of one lookup
   typedef struct packed {
      tgt_type target;
      logic    hit;
   } btb_resp_t;

   // One row of the directed table. Rows with typed set carry an expected
   // response that can be read straight off the behavior; the rest go
   // through the predictor.
   typedef struct {
      logic            func;
      logic [PC_W-1:0] pc;
      tgt_type         new_target;
      bit              typed;
      tgt_type         exp_target;
      logic            exp_hit;
   } directed_row_t;

   localparam int N_DIRECTED = 24;

   // Set 0 / offset 0 lines use pc = tag << 8. The first update lands in the
   // newest way, the next ones in the remaining empty ways, and the update of
   // 0x500 finds the set full and pushes out the oldest way.
   directed_row_t directed_rows [N_DIRECTED] = '{
      // after reset everything misses
      '{FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0004, 1'b0},
      '{FUNC_LOOKUP, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
      '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0003, 1'b0},
      // fill, hit, hit through unaligned pc, miss at the next offset
      '{FUNC_UPDATE, 32'h0000_0100, 32'hDEAD_BEEF, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF, 1'b1},
      '{FUNC_LOOKUP, 32'h0000_0103, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF, 1'b1},
      '{FUNC_LOOKUP, 32'h0000_0104, 32'hA5A5_A5A5, 1'b1, 32'h0000_0108, 1'b0},
      // rewrite on update hit
      '{FUNC_UPDATE, 32'h0000_0100, 32'h1234_5678, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b1, 32'h1234_5678, 1'b1},
      // fill the remaining ways of set 0
      '{FUNC_UPDATE, 32'h0000_0200, 32'h2000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_UPDATE, 32'h0000_0300, 32'h3000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_UPDATE, 32'h0000_0400, 32'h4000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0400, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      // set full: oldest way goes, fresh line at the newest position
      '{FUNC_UPDATE, 32'h0000_0500, 32'h5000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0400, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0500, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      // other offset, no empty line: another eviction
      '{FUNC_UPDATE, 32'h0000_0504, 32'h5000_0004, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0504, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0500, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      // extremes of pc and target
      '{FUNC_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{FUNC_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0,        1'b0},
      '{FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0,        1'b0}
   };

   // Clock, reset and DUT ports; all driven inputs known from time zero
   logic            clock          = 1'b0;
   logic            reset          = 1'b1;
   logic            req_valid      = 1'b0;
   logic            req_stall;
   logic            req_func       = FUNC_LOOKUP;
   logic [PC_W-1:0] req_pc         = '0;
   tgt_type         req_new_target = '0;
   logic            rsp_valid;
   logic            rsp_stall      = 1'b0;
   tgt_type         rsp_predicted_target;
   logic            rsp_hit;

   // Predictor state: a shadow of the table and of the per-set way order
   tag_type   btb_tag    [NUM_SETS][NUM_WAYS][LINE_ENTRIES];
   tgt_type   btb_target [NUM_SETS][NUM_WAYS][LINE_ENTRIES];
   line_type  btb_valid  [NUM_SETS][NUM_WAYS];
   way_type   fifo_order [NUM_SETS][NUM_WAYS];   // position 0 = oldest way

   // Responses still owed by the DUT, oldest first
   btb_resp_t pending_lookups [$];
   btb_resp_t want;

   // Traffic shaping shared between the sender and the receiver
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          long_hold_req = 1'b0;
   int unsigned hold_left     = 0;

   // Bookkeeping
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned lookups_sent  = 0;
   int unsigned updates_sent  = 0;
   int unsigned hits_seen     = 0;

   set_assoc_branch_target_buffer DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_pc               (req_pc),
      .req_new_target       (req_new_target),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_predicted_target (rsp_predicted_target),
      .rsp_hit              (rsp_hit)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one accepted request to the shadow table. Returns 1 with the
   // expected response for a lookup; an update changes state and returns 0.
   function automatic bit btb_predict(input logic func, input logic [PC_W-1:0] pc,
                                      input tgt_type new_target, output btb_resp_t rsp);
      off_type off;
      idx_type idx;
      tag_type tag;
      way_type w;
      way_type hit_way;
      way_type empty_way;
      bit      found;
      bit      have_empty;
      // bits 1..0 take no part in the split
      off = pc[WORD_SHIFT +: OFF_W];
      idx = pc[WORD_SHIFT + OFF_W +: IDX_W];
      tag = pc[PC_W-1 -: TAG_W];
      rsp.target = pc + PC_STEP;   // miss: full pc + 4, wraps
      rsp.hit    = 1'b0;
      found      = 1'b0;
      have_empty = 1'b0;
      hit_way    = '0;
      empty_way  = '0;
      // oldest to newest; first match wins, last empty line is the newest one
      for (int p = 0; p < NUM_WAYS; p++) begin
         w = fifo_order[idx][p];
         if (!found && btb_valid[idx][w][off] && btb_tag[idx][w][off] == tag) begin
            found      = 1'b1;
            hit_way    = w;
            rsp.hit    = 1'b1;
            rsp.target = btb_target[idx][w][off];
         end
         if (btb_valid[idx][w] == '0) begin
            have_empty = 1'b1;
            empty_way  = w;
         end
      end
      if (func == FUNC_LOOKUP)
         return 1'b1;
      if (found) begin
         btb_target[idx][hit_way][off] = new_target;
         return 1'b0;
      end
      if (!have_empty) begin
         // drop the oldest way and reuse it as the newest, line cleared
         empty_way = fifo_order[idx][0];
         for (int p = 0; p < NUM_WAYS - 1; p++)
            fifo_order[idx][p] = fifo_order[idx][p+1];
         fifo_order[idx][NUM_WAYS-1] = empty_way;
         btb_valid[idx][empty_way]   = '0;
      end
      btb_tag[idx][empty_way][off]    = tag;
      btb_target[idx][empty_way][off] = new_target;
      btb_valid[idx][empty_way][off]  = 1'b1;
      return 1'b0;
   endfunction

   // Offers one request, holding it until the DUT takes it, then predicts.
   // Called right after a rising edge; every path leaves at a rising edge
   // without a pending assignment to req_valid in that step.
   task automatic send_request(input logic func, input logic [PC_W-1:0] pc,
                               input tgt_type new_target, input bit typed,
                               input tgt_type typed_target, input logic typed_hit);
      btb_resp_t rsp;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_pc         <= pc;
      req_new_target <= new_target;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (func == FUNC_LOOKUP)
         lookups_sent++;
      else
         updates_sent++;
      if (btb_predict(func, pc, new_target, rsp)) begin
         if (typed) begin
            rsp.target = typed_target;
            rsp.hit    = typed_hit;
         end
         pending_lookups = {pending_lookups, rsp};
      end
   endtask

   // Sender goes quiet until every owed response has arrived.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off on request from the
   // sender so the pipeline backs up into req_stall.
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Response checker: every taken response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response: target %h hit %b",
                        rsp_predicted_target, rsp_hit);
         end else begin
            want = pending_lookups.pop_front();
            if (want.hit)
               hits_seen++;
            if (rsp_predicted_target !== want.target || rsp_hit !== want.hit) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: target exp %h got %h, hit exp %b got %b",
                           want.target, rsp_predicted_target, want.hit, rsp_hit);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [PC_W-1:0] pc;
      logic            func;

      // all entries invalid, ways ordered 0 (oldest) .. last (newest)
      foreach (fifo_order[s, p])
         fifo_order[s][p] = way_type'(p);
      foreach (btb_valid[s, w])
         btb_valid[s][w] = '0;

      send_idle_pct = 37;
      recv_idle_pct = 53;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].pc,
                      directed_rows[i].new_target, directed_rows[i].typed,
                      directed_rows[i].exp_target, directed_rows[i].exp_hit);
      wait_for_responses();

      // Random traffic. Most pcs come from a small pool of tags in a few
      // sets so lines hit, refill and get evicted; some are fully random,
      // and some pool tags are inverted to exercise the top address bits.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 53 : 0;
         recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 37 : 0;
         if (ph == 2)
            long_hold_req = 1'b1;   // back up the pipe with no idling
         repeat (RANDOM_PER_PHASE) begin
            func = ($urandom_range(99) < 60) ? FUNC_LOOKUP : FUNC_UPDATE;
            if ($urandom_range(9) == 0) begin
               pc = $urandom();
            end else begin
               pc = {tag_type'($urandom_range(7)), idx_type'($urandom_range(3)),
                     off_type'($urandom_range(LINE_ENTRIES - 1)),
                     WORD_SHIFT'($urandom_range(3))};
               if ($urandom_range(3) == 0)
                  pc[PC_W-1 -: TAG_W] = ~pc[PC_W-1 -: TAG_W];
            end
            send_request(func, pc, tgt_type'($urandom()), 1'b0, '0, 1'b0);
         end
         wait_for_responses();
      end

      // let anything stray drain out of the two-stage pipe
      repeat (8) @(posedge clock);

      $display("Sent %0d lookups and %0d updates (%0d hits) over fills, rewrites,",
               lookups_sent, updates_sent, hits_seen);
      $display("FIFO evictions and wrapping pcs, with idle and stall on both sides.");
      if (error_count == 0 && pending_lookups.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
